// File: rtl/char_lcd_nibble_write_queue_top_defines.svh
// assertion macros shared by the checker
`ifndef CHAR_LCD_NIBBLE_WRITE_QUEUE_TOP_DEFINES_SVH
`define CHAR_LCD_NIBBLE_WRITE_QUEUE_TOP_DEFINES_SVH

// consequent holds in the same cycle as the antecedent
`define CNWQ_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent holds in the cycle after the antecedent
`define CNWQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/cnwq_pkg.sv
package cnwq_pkg;

	localparam int QUEUE_DEPTH_DEF = 64;

	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 8;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_ENABLE_HIGH   = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_NIBBLE_PERIOD = 1'b1;

	// item kinds
	localparam logic KIND_PUSH = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	localparam logic [7:0] ESCAPE_BYTE           = 8'd27;
	localparam logic [7:0] ENABLE_HIGH_RESET     = 8'd2;
	localparam logic [7:0] NIBBLE_PERIOD_RESET   = 8'd40;
	localparam int         QUEUED_W              = 6;

	// controller to datapath
	typedef struct packed {
		logic step;   // apply accepted item
		logic take;   // read next queued byte
		logic check;  // act on byte just read
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic take_needed;
		logic queue_empty;
		logic is_escape;
	} status_t;

endpackage

// File: rtl/cnwq_ctrl.sv
module cnwq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  cnwq_pkg::status_t status,
	output cnwq_pkg::cmd_t    cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_TAKE  = 2'd1;
	localparam logic [1:0] ST_CHECK = 2'd2;
	localparam logic [1:0] ST_OUT   = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_OUT);

	always_comb begin
		cmd.step  = 1'b0;
		cmd.take  = 1'b0;
		cmd.check = 1'b0;
		state_d   = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.step = 1'b1;
					state_d  = status.take_needed ? ST_TAKE : ST_OUT;
				end
			end
			ST_TAKE: begin
				if (status.queue_empty) begin
					state_d = ST_OUT;
				end else begin
					cmd.take = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				cmd.check = 1'b1;
				// escape bytes are skipped, keep fetching
				state_d   = status.is_escape ? ST_TAKE : ST_OUT;
			end
			ST_OUT: begin
				if (!out_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: rtl/cnwq_datapath.sv
module cnwq_datapath #(
	parameter int QUEUE_DEPTH = cnwq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write_en,
	input  logic [cnwq_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [cnwq_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                kind,
	input  logic [7:0]                          byte_value,
	input  cnwq_pkg::cmd_t                      cmd,
	output cnwq_pkg::status_t                   status,
	output logic [3:0]                          data_nibble,
	output logic                                register_select,
	output logic                                enable_strobe,
	output logic                                transfer_busy,
	output logic                                push_accepted,
	output logic [cnwq_pkg::QUEUED_W-1:0]       queued_bytes
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int EXT_W = (PTR_W > cnwq_pkg::QUEUED_W) ? PTR_W : cnwq_pkg::QUEUED_W;
	localparam logic [PTR_W-1:0] LAST_POS = PTR_W'(QUEUE_DEPTH - 1);

	logic [7:0]       queue_mem [QUEUE_DEPTH];
	logic [7:0]       rdata_q;
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [PTR_W-1:0] count_q;
	logic             cmd_pend_q;
	logic             low_pend_q;
	logic [7:0]       in_flight_q;
	logic             pulse_q;
	logic [7:0]       tick_q;
	logic [3:0]       nibble_q;
	logic             rs_q;
	logic             en_q;
	logic             accepted_q;
	logic [7:0]       enable_high_q;
	logic [7:0]       period_q;

	logic             full;
	logic             push_ok;
	logic             mem_we;
	logic [7:0]       tick_inc;
	logic             period_end;
	logic [EXT_W-1:0] count_ext;

	assign full       = (count_q == LAST_POS);
	assign push_ok    = (kind == cnwq_pkg::KIND_PUSH) && !full;
	assign mem_we     = cmd.step && push_ok;
	assign tick_inc   = tick_q + 8'd1;
	assign period_end = (tick_inc == period_q);

	assign status.take_needed = (push_ok && !pulse_q)
		|| ((kind == cnwq_pkg::KIND_TICK) && pulse_q && period_end && !low_pend_q);
	assign status.queue_empty = (count_q == '0);
	assign status.is_escape   = (rdata_q == cnwq_pkg::ESCAPE_BYTE);

	assign count_ext       = EXT_W'(count_q);
	assign queued_bytes    = count_ext[cnwq_pkg::QUEUED_W-1:0];
	assign data_nibble     = nibble_q;
	assign register_select = rs_q;
	assign enable_strobe   = en_q;
	assign transfer_busy   = pulse_q;
	assign push_accepted   = accepted_q;

	// byte queue, written on accepted pushes, read one byte per fetch
	always_ff @(posedge clk) begin
		if (mem_we) begin
			queue_mem[wr_q] <= byte_value;
		end
		if (cmd.take) begin
			rdata_q <= queue_mem[rd_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_high_q <= cnwq_pkg::ENABLE_HIGH_RESET;
			period_q      <= cnwq_pkg::NIBBLE_PERIOD_RESET;
		end else if (cfg_write_en) begin
			case (cfg_index)
				cnwq_pkg::REG_ENABLE_HIGH:   enable_high_q <= cfg_data;
				cnwq_pkg::REG_NIBBLE_PERIOD: period_q      <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q        <= '0;
			rd_q        <= '0;
			count_q     <= '0;
			cmd_pend_q  <= 1'b0;
			low_pend_q  <= 1'b0;
			in_flight_q <= '0;
			pulse_q     <= 1'b0;
			tick_q      <= '0;
			nibble_q    <= '0;
			rs_q        <= 1'b1;
			en_q        <= 1'b0;
			accepted_q  <= 1'b0;
		end else if (cmd.step) begin
			accepted_q <= mem_we;
			if (mem_we) begin
				wr_q    <= (wr_q == LAST_POS) ? '0 : wr_q + PTR_W'(1);
				count_q <= count_q + PTR_W'(1);
			end
			if ((kind == cnwq_pkg::KIND_TICK) && pulse_q) begin
				if (period_end && low_pend_q) begin
					// second nibble of the byte in flight
					low_pend_q <= 1'b0;
					cmd_pend_q <= 1'b0;
					en_q       <= 1'b1;
					tick_q     <= '0;
					nibble_q   <= in_flight_q[3:0];
				end else begin
					tick_q <= tick_inc;
					if (period_end) begin
						en_q    <= 1'b0;
						pulse_q <= 1'b0;
					end else if (tick_inc == enable_high_q) begin
						en_q <= 1'b0;
					end
				end
			end
		end else if (cmd.take) begin
			rd_q    <= (rd_q == LAST_POS) ? '0 : rd_q + PTR_W'(1);
			count_q <= count_q - PTR_W'(1);
		end else if (cmd.check) begin
			if (rdata_q == cnwq_pkg::ESCAPE_BYTE) begin
				cmd_pend_q <= 1'b1;
			end else begin
				rs_q        <= !cmd_pend_q;
				in_flight_q <= rdata_q;
				low_pend_q  <= 1'b1;
				nibble_q    <= rdata_q[7:4];
				en_q        <= 1'b1;
				pulse_q     <= 1'b1;
				tick_q      <= '0;
			end
		end
	end

endmodule

// File: rtl/char_lcd_nibble_write_queue_top.sv
// result: shown in the cycle after acceptance when no queued byte is fetched;
// each byte read from the queue adds a queue read step, then a decode step, skipped
// escape bytes count as reads, and a fetch that finds the queue empty adds a read step
// one item in the block at a time, the next is accepted only after the result leaves
// reset: asynchronous, queue empty, register select high, enable low, registers
// at 2 and 40 ticks; queue contents are not cleared and need no sweep
module char_lcd_nibble_write_queue_top #(
	parameter int QUEUE_DEPTH = cnwq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration writes
	input  logic                             cfg_write_en,
	input  logic [cnwq_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [cnwq_pkg::CFG_DATA_W-1:0]  cfg_data,
	// input item
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             kind,
	input  logic [7:0]                       byte_value,
	// result item
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [3:0]                       data_nibble,
	output logic                             register_select,
	output logic                             enable_strobe,
	output logic                             transfer_busy,
	output logic                             push_accepted,
	output logic [cnwq_pkg::QUEUED_W-1:0]    queued_bytes
);

	// command and status between the sequencer and the datapath
	cnwq_pkg::cmd_t    cmd;
	cnwq_pkg::status_t status;

	// sequencer: accept item, fetch queued bytes while escapes are skipped, show result
	cnwq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	// datapath: ring queue memory, nibble timer, line levels, config registers
	// outputs come straight from registers and hold while the result is stalled
	cnwq_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_write_en    (cfg_write_en),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.kind            (kind),
		.byte_value      (byte_value),
		.cmd             (cmd),
		.status          (status),
		.data_nibble     (data_nibble),
		.register_select (register_select),
		.enable_strobe   (enable_strobe),
		.transfer_busy   (transfer_busy),
		.push_accepted   (push_accepted),
		.queued_bytes    (queued_bytes)
	);

endmodule

// File: rtl/cnwq_checker.sv
`include "char_lcd_nibble_write_queue_top_defines.svh"

module cnwq_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [3:0]                    data_nibble,
	input logic                          enable_strobe,
	input logic                          transfer_busy,
	input logic [cnwq_pkg::QUEUED_W-1:0] queued_bytes
);

	`CNWQ_ASSERT_NEXT(a_out_held, out_valid && out_stall, out_valid, "result dropped while stalled")
	`CNWQ_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(data_nibble) && $stable(queued_bytes), "stalled result changed")
	`CNWQ_ASSERT_NEXT(a_one_item, in_valid && !in_stall, in_stall, "second item taken before result")
	`CNWQ_ASSERT_SAME(a_enable_busy, out_valid && enable_strobe, transfer_busy, "enable high outside a transfer")

endmodule

bind char_lcd_nibble_write_queue_top cnwq_checker u_cnwq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.data_nibble   (data_nibble),
	.enable_strobe (enable_strobe),
	.transfer_busy (transfer_busy),
	.queued_bytes  (queued_bytes)
);
